// ===== hdl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// String frame decoder package
// Shared types, character codes and result codes for the frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

   localparam int LengthBitsDefault = 32;
   localparam int CountBits         = 32;
   localparam int ReportBits        = 32;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_BANG   = 8'h21;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   typedef enum logic [2:0] {
      PHASE_IDLE   = 3'd0,
      PHASE_LEN    = 3'd1,
      PHASE_LEN_LF = 3'd2,
      PHASE_DATA   = 3'd3,
      PHASE_END_LF = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_DONE = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CAUSE_NONE     = 3'd0,
      CAUSE_PREFIX   = 3'd1,
      CAUSE_DIGIT    = 3'd2,
      CAUSE_LF       = 3'd3,
      CAUSE_OVERFLOW = 3'd4
   } cause_type;

   typedef struct packed {
      kind_type               kind;
      logic [7:0]             payload_byte;
      logic [ReportBits-1:0]  declared_length;
      logic [CountBits-1:0]   received_count;
      logic                   error_reply;
      cause_type              error_cause;
   } result_type;

endpackage

// ===== hdl/sfd_if.sv =====
// ----------------------------------------------------------------------------
// String frame decoder channel interfaces
// Valid/ready channels for input bytes, decode results and the control word.
// ----------------------------------------------------------------------------
interface sfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface sfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  payload_byte;
   logic [31:0] declared_length;
   logic [31:0] received_count;
   logic        error_reply;
   logic [2:0]  error_cause;

   modport source (output valid, output kind, output payload_byte,
                   output declared_length, output received_count,
                   output error_reply, output error_cause, input ready);
   modport sink   (input valid, input kind, input payload_byte,
                   input declared_length, input received_count,
                   input error_reply, input error_cause, output ready);
endinterface

interface sfd_csr_if;
   logic valid;
   logic ready;
   logic allow_error_prefix;

   modport source (output valid, output allow_error_prefix, input ready);
   modport sink   (input valid, input allow_error_prefix, output ready);
endinterface

// ===== hdl/sfd_parser.sv =====
// ----------------------------------------------------------------------------
// String frame decoder parser
// Per-byte state machine with the length accumulator and payload counter.
// ----------------------------------------------------------------------------
module sfd_parser #(
   parameter int LENGTH_BITS = sfd_pkg::LengthBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_accept,
   input  logic [7:0]          in_byte,
   input  logic                allow_error_prefix,
   output logic                result_valid,
   output sfd_pkg::result_type result
);

   localparam int CountBits  = sfd_pkg::CountBits;
   localparam int ReportBits = sfd_pkg::ReportBits;
   localparam int ProdBits   = LENGTH_BITS + 4;

   sfd_pkg::phase_type     phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [CountBits-1:0]   count_ff, count_in;
   logic                   mark_ff, mark_in;

   logic                          is_digit;
   logic [7:0]                    digit_full;
   logic [3:0]                    digit;
   logic [ProdBits-1:0]           acc_ext;
   logic [ProdBits-1:0]           acc_next;
   logic                          overflow;
   logic [LENGTH_BITS+ReportBits-1:0] length_report;

   assign is_digit   = (in_byte >= sfd_pkg::CHAR_ZERO) && (in_byte <= sfd_pkg::CHAR_NINE);
   assign digit_full = in_byte - sfd_pkg::CHAR_ZERO;
   assign digit      = digit_full[3:0];
   assign acc_ext    = {4'b0000, length_ff};
   // Times ten as eight plus two; any bit above the length width is overflow.
   assign acc_next   = (acc_ext << 3) + (acc_ext << 1) + {{(ProdBits-4){1'b0}}, digit};
   assign overflow   = |acc_next[ProdBits-1:LENGTH_BITS];
   assign length_report = {{ReportBits{1'b0}}, length_ff};

   always_comb begin
      phase_in            = phase_ff;
      length_in           = length_ff;
      count_in            = count_ff;
      mark_in             = mark_ff;
      result_valid        = 1'b0;
      result.kind            = sfd_pkg::KIND_BYTE;
      result.payload_byte    = 8'h00;
      result.declared_length = '0;
      result.received_count  = '0;
      result.error_reply     = 1'b0;
      result.error_cause     = sfd_pkg::CAUSE_NONE;

      if (byte_accept) begin
         case (phase_ff)
            sfd_pkg::PHASE_IDLE: begin
               if ((in_byte == sfd_pkg::CHAR_DOLLAR) ||
                   ((in_byte == sfd_pkg::CHAR_BANG) && allow_error_prefix)) begin
                  length_in = '0;
                  count_in  = '0;
                  mark_in   = (in_byte == sfd_pkg::CHAR_BANG);
                  phase_in  = sfd_pkg::PHASE_LEN;
               end else begin
                  result_valid       = 1'b1;
                  result.kind        = sfd_pkg::KIND_ERR;
                  result.error_cause = sfd_pkg::CAUSE_PREFIX;
               end
            end
            sfd_pkg::PHASE_LEN: begin
               if (in_byte == sfd_pkg::CHAR_CR) begin
                  phase_in = sfd_pkg::PHASE_LEN_LF;
               end else if (is_digit && !overflow) begin
                  length_in = acc_next[LENGTH_BITS-1:0];
               end else begin
                  result_valid       = 1'b1;
                  result.kind        = sfd_pkg::KIND_ERR;
                  result.error_cause = is_digit ? sfd_pkg::CAUSE_OVERFLOW
                                                : sfd_pkg::CAUSE_DIGIT;
               end
            end
            sfd_pkg::PHASE_LEN_LF: begin
               if (in_byte == sfd_pkg::CHAR_LF) begin
                  count_in = '0;
                  phase_in = sfd_pkg::PHASE_DATA;
               end else begin
                  result_valid       = 1'b1;
                  result.kind        = sfd_pkg::KIND_ERR;
                  result.error_cause = sfd_pkg::CAUSE_LF;
               end
            end
            sfd_pkg::PHASE_DATA: begin
               if (in_byte == sfd_pkg::CHAR_CR) begin
                  phase_in = sfd_pkg::PHASE_END_LF;
               end else begin
                  if (count_ff != {CountBits{1'b1}}) begin
                     count_in = count_ff + {{(CountBits-1){1'b0}}, 1'b1};
                  end
                  result_valid        = 1'b1;
                  result.kind         = sfd_pkg::KIND_BYTE;
                  result.payload_byte = in_byte;
               end
            end
            sfd_pkg::PHASE_END_LF: begin
               result_valid = 1'b1;
               if (in_byte == sfd_pkg::CHAR_LF) begin
                  result.kind            = sfd_pkg::KIND_DONE;
                  result.declared_length = length_report[ReportBits-1:0];
                  result.received_count  = count_ff;
                  result.error_reply     = mark_ff;
               end else begin
                  result.kind        = sfd_pkg::KIND_ERR;
                  result.error_cause = sfd_pkg::CAUSE_LF;
               end
            end
            default: begin
            end
         endcase

         // Every result other than a payload byte ends the frame.
         if ((result_valid && (result.kind != sfd_pkg::KIND_BYTE)) ||
             ((phase_ff != sfd_pkg::PHASE_IDLE) && (phase_ff != sfd_pkg::PHASE_LEN) &&
              (phase_ff != sfd_pkg::PHASE_LEN_LF) && (phase_ff != sfd_pkg::PHASE_DATA) &&
              (phase_ff != sfd_pkg::PHASE_END_LF))) begin
            phase_in  = sfd_pkg::PHASE_IDLE;
            length_in = '0;
            count_in  = '0;
            mark_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= sfd_pkg::PHASE_IDLE;
         length_ff <= '0;
         count_ff  <= '0;
         mark_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         mark_ff   <= mark_in;
      end
   end

`ifndef SYNTHESIS
   a_error_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (result_valid && (result.kind == sfd_pkg::KIND_ERR)) |=>
         (phase_ff == sfd_pkg::PHASE_IDLE))
      else $error("parser did not return to idle after a framing error");

   a_idle_is_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == sfd_pkg::PHASE_IDLE) |-> ((length_ff == '0) && (count_ff == '0) && !mark_ff))
      else $error("frame state not cleared while idle");

   a_done_only_after_cr: assert property (@(posedge clock) disable iff (reset)
      (result_valid && (result.kind == sfd_pkg::KIND_DONE)) |->
         (phase_ff == sfd_pkg::PHASE_END_LF))
      else $error("frame completion outside the closing terminator");
`endif

endmodule

// ===== hdl/sfd_out_buffer.sv =====
// ----------------------------------------------------------------------------
// String frame decoder output buffer
// Result register with one skid entry so the input keeps moving under stall.
// ----------------------------------------------------------------------------
module sfd_out_buffer (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  sfd_pkg::result_type push_result,
   output logic                push_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output sfd_pkg::result_type out_result
);

   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   sfd_pkg::result_type out_ff, out_in;
   sfd_pkg::result_type skid_ff, skid_in;
   logic                out_free;

   assign push_ready = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;
   assign out_free   = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (push_valid) begin
            out_in       = push_result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push_valid) begin
         skid_in       = push_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while the result register is empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push_ready)
      else $error("buffer ready while the skid entry is occupied");

   a_held_result_kept: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |=> out_valid_ff)
      else $error("stalled result dropped");
`endif

endmodule

// ===== hdl/string_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// String frame decoder
// Streaming decoder for length-prefixed string frames, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
// - req_bus carries one raw stream byte per word. Frames look like a prefix
//   ('$', or '!' for an error reply when enabled), a decimal length, CR LF,
//   payload bytes and a closing CR LF.
// - rsp_bus carries at most one result word per input byte: each payload byte
//   as it arrives, a completion word on the closing LF with the declared
//   length, the payload count and the error-reply mark, or a framing error
//   word with its cause. After an error the parser is back in idle.
// - csr_bus writes the one control bit that enables the '!' prefix. It is
//   always ready; write it only while the decoder is idle.
// Timing: one byte is taken every cycle while the skid entry is free. A
// result is registered in the output buffer before it shows on rsp_bus; the
// per-byte state update and times-ten length accumulate are combinational.
// Reset: synchronous and active high; the parser returns to idle, the result
// register and skid entry empty, and the '!' prefix is enabled.
// Stall: while rsp_bus is held, one more result is caught in a skid entry;
// req_bus.ready drops only once that entry is occupied.
// ----------------------------------------------------------------------------
module string_frame_decoder #(
   parameter int LENGTH_BITS = sfd_pkg::LengthBitsDefault
) (
   input  logic            clock,
   input  logic            reset,
   sfd_req_if.sink         req_bus,
   sfd_rsp_if.source       rsp_bus,
   sfd_csr_if.sink         csr_bus
);

   // Control bit: enables the error-reply prefix, set by reset.
   logic allow_error_prefix_ff, allow_error_prefix_in;

   logic                byte_accept;
   logic                result_valid;
   sfd_pkg::result_type result;
   sfd_pkg::result_type out_result;
   logic                push_ready;

   // The control port never stalls.
   assign csr_bus.ready = 1'b1;
   assign allow_error_prefix_in = (csr_bus.valid && csr_bus.ready) ?
                                  csr_bus.allow_error_prefix : allow_error_prefix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_error_prefix_ff <= 1'b1;
      end else begin
         allow_error_prefix_ff <= allow_error_prefix_in;
      end
   end

   // A byte is taken whenever the skid entry is free, so the input keeps
   // flowing while one finished result waits on the output.
   assign req_bus.ready = push_ready;
   assign byte_accept   = req_bus.valid && push_ready;

   sfd_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock              (clock),
      .reset              (reset),
      .byte_accept        (byte_accept),
      .in_byte            (req_bus.in_byte),
      .allow_error_prefix (allow_error_prefix_ff),
      .result_valid       (result_valid),
      .result             (result)
   );

   sfd_out_buffer u_out_buffer (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (result_valid),
      .push_result (result),
      .push_ready  (push_ready),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .out_result  (out_result)
   );

   assign rsp_bus.kind            = out_result.kind;
   assign rsp_bus.payload_byte    = out_result.payload_byte;
   assign rsp_bus.declared_length = out_result.declared_length;
   assign rsp_bus.received_count  = out_result.received_count;
   assign rsp_bus.error_reply     = out_result.error_reply;
   assign rsp_bus.error_cause     = out_result.error_cause;

`ifndef SYNTHESIS
   a_csr_write_lands: assert property (@(posedge clock) disable iff (reset)
      (csr_bus.valid && csr_bus.ready) |=>
         (allow_error_prefix_ff == $past(csr_bus.allow_error_prefix)))
      else $error("control write not captured");

   a_result_needs_byte: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> byte_accept)
      else $error("result produced without an accepted byte");

   a_bang_rejected_when_off: assert property (@(posedge clock) disable iff (reset)
      (byte_accept && !allow_error_prefix_ff && (req_bus.in_byte == sfd_pkg::CHAR_BANG) &&
       !result_valid) |-> (result.error_reply == 1'b0))
      else $error("error-reply result while the prefix is disabled");
`endif

endmodule
